>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the table interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define ASSERT_IMPLY_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/core/dti_pkg.sv
// Shared types, constants and codes of the descending table interpolator.
package dti_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 128;
    localparam int QUEUE_DEPTH         = 2;
    localparam int VALUE_W             = 24;
    localparam int INDEX_W             = 7;
    localparam int TEMP_W              = 17;
    localparam int FRAC_W              = 9;
    localparam int DIV_STEPS           = 9;
    // Dividend (reading - low) * 512 + span and divisor 2 * span.
    localparam int NUM_W               = 34;
    localparam int DEN_W               = 25;

    localparam logic signed [7:0] START_RESET   = -8'sd10;
    localparam logic [7:0]        ENTRIES_RESET = 8'd128;

    localparam int TEMP_MIN = -32768;
    localparam int TEMP_MAX = 65535;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic REG_START   = 1'b0;
    localparam logic REG_ENTRIES = 1'b1;

    typedef struct packed {
        logic                command;
        logic [INDEX_W-1:0]  entry_index;
        logic [VALUE_W-1:0]  entry_value;
        logic [VALUE_W-1:0]  search_value;
    } in_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_q8;
        logic                     above_first;
        logic                     below_last;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0] start_temperature;
        logic [7:0]        entries_in_use;
    } cfg_t;

    typedef struct packed {
        logic                lookup;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
    } queue_entry_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_FINISH
    } back_state_t;

endpackage

>>> rtl/core/descending_table_interpolator.sv
// Top level of the descending table interpolator: register port, front, back, RAM, divider.
//
// The block turns a resistance reading into a temperature by linear interpolation
// in a table of resistances that falls as temperature rises. A transaction is
// accepted at a rising edge with start high and busy low. A load transaction
// writes one table word and gives no result; a lookup transaction gives one
// result, shown on result for exactly one cycle while done is high. The receiver
// cannot hold results off, so a result is simply taken in the cycle it appears.
// Accepted transactions enter a two-entry queue; busy is high while it is full.
// The back end takes one transaction at a time from the queue. A load is written
// to the table from the idle state. A lookup that stops at table index i gives its
// result after the scan reaches i if a flag is raised, and after the divider too if
// it interpolates, plus any time spent waiting behind earlier transactions. The
// scan reads one table word per cycle through the RAM's registered read port and
// the fraction takes one divider step per cycle for nine quotient bits.
// Registers: start_temperature at byte address 0, entries_in_use at address 4.
// Reset empties the queue, idles the back end and restores the register defaults
// (start temperature -10, 128 entries); the table holds no defined data until
// it is loaded.
`include "assert_macros.svh"
module descending_table_interpolator
    import dti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic signed [7:0] start_temperature_reg, start_temperature_next;
    logic [7:0]        entries_in_use_reg, entries_in_use_next;
    logic              cfg_write;
    cfg_t              cfg;

    queue_entry_t      head;
    logic              head_valid;
    logic              pop;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // The register port never waits, so every access completes in its access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        start_temperature_next = start_temperature_reg;
        entries_in_use_next    = entries_in_use_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_START:   start_temperature_next = signed'(pwdata[7:0]);
                REG_ENTRIES: entries_in_use_next    = pwdata[7:0];
                default:     entries_in_use_next    = entries_in_use_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_temperature_reg <= START_RESET;
            entries_in_use_reg    <= ENTRIES_RESET;
        end
        else
        begin
            start_temperature_reg <= start_temperature_next;
            entries_in_use_reg    <= entries_in_use_next;
        end
    end

    // Reads return the start temperature sign-extended and the entry count as is.
    always_comb
    begin
        unique case (paddr[2])
            REG_START:   prdata = 32'(start_temperature_reg);
            REG_ENTRIES: prdata = 32'(entries_in_use_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.start_temperature = start_temperature_reg;
    assign cfg.entries_in_use    = entries_in_use_reg;

    dti_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dti_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dti_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .done        (done),
        .result      (result)
    );

    // A result never carries both flags.
    `ASSERT_IMPLY(a_flags_exclusive, clk, rst_n, done, !(result.above_first && result.below_last))
    // Each lookup yields a single strobe, so done never stays high into the cycle after it.
    `ASSERT_IMPLY_NEXT(a_done_single, clk, rst_n, done, !done)
    // A reading at or above the first entry returns the start temperature in whole degrees.
    `ASSERT_IMPLY(a_above_value, clk, rst_n, done && result.above_first, result.temperature_q8 == (start_temperature_reg * 17'sd256))
    // The back end only takes a transaction that the queue actually holds.
    `ASSERT_IMPLY(a_pop_valid, clk, rst_n, pop, head_valid)

endmodule

>>> rtl/core/dti_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dti_ram
    import dti_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/dti_front.sv
// Front end: accepts transactions, drops out-of-range loads and queues the rest.
module dti_front
    import dti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  in_item_t     item,
    output queue_entry_t head,
    output logic         head_valid,
    input  logic         pop
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t   slot_reg [QUEUE_DEPTH];
    queue_entry_t   entry;
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           accept;
    logic           keep;
    logic           push;
    logic           do_pop;

    assign busy       = (count_reg == QCW'(QUEUE_DEPTH));
    assign accept     = start && !busy;
    // A load beyond the table is accepted but has no effect.
    assign keep       = (item.command == CMD_LOOKUP) ||
                        (CW'(item.entry_index) < CW'(TABLE_DEPTH));
    assign push       = accept && keep;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        entry.lookup = (item.command == CMD_LOOKUP);
        entry.index  = item.entry_index;
        entry.value  = (item.command == CMD_LOOKUP) ? item.search_value : item.entry_value;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCW'(push) - QCW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/core/dti_div.sv
// Restoring divider that yields one quotient bit per cycle for the fraction.
module dti_div
    import dti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  den_reg, den_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  diff;
    logic              take;

    assign diff = rem_reg - den_reg;
    assign take = (rem_reg >= den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.dividend;
            den_next = NUM_W'(req.divisor) << (DIV_STEPS - 1);
            quo_next = '0;
            cnt_next = CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (take)
            begin
                rem_next = diff;
            end
            quo_next  = {quo_reg[FRAC_W-2:0], take};
            den_next  = den_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/core/dti_back.sv
// Back end: table writes, the linear scan, the fraction request and result assembly.
module dti_back
    import dti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  queue_entry_t                   head,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           ram_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
    output logic [VALUE_W-1:0]             ram_wr_data,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
    input  logic [VALUE_W-1:0]             ram_rd_data,
    output div_req_t                       div_req,
    input  div_rsp_t                       div_rsp,
    output logic                           done,
    output out_item_t                      result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int TW = (AW + 11 > TEMP_W + 1) ? AW + 11 : TEMP_W + 1;
    localparam logic signed [TW-1:0] TMIN = TW'(TEMP_MIN);
    localparam logic signed [TW-1:0] TMAX = TW'(TEMP_MAX);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [VALUE_W-1:0] reading_reg, reading_next;
    logic [VALUE_W-1:0] prev_reg, prev_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              above_reg, above_next;
    logic              below_reg, below_next;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;

    logic [CW-1:0]     n_in;
    logic [CW-1:0]     n_eff;
    logic [AW-1:0]     last_idx;
    logic              hit;
    logic [VALUE_W-1:0] span;
    logic [VALUE_W-1:0] offset;
    logic signed [TW-1:0] base_w;
    logic signed [TW-1:0] idx_w;
    logic signed [TW-1:0] whole;
    logic signed [TW-1:0] temp;
    logic signed [TW-1:0] clamped;

    // Scan length: zero counts as one, anything past the table as the whole table.
    always_comb
    begin
        n_in = CW'(cfg.entries_in_use);
        priority if (n_in == '0)
        begin
            n_eff = CW'(1);
        end
        else if (n_in > CW'(TABLE_DEPTH))
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = n_in;
        end
        last_idx = AW'(n_eff - CW'(1));
    end

    assign hit    = (reading_reg >= ram_rd_data);
    assign span   = prev_reg - ram_rd_data;
    assign offset = reading_reg - ram_rd_data;

    assign div_req.start    = (state_reg == ST_SCAN) && hit && (idx_reg != '0);
    assign div_req.dividend = NUM_W'({offset, 9'b0}) + NUM_W'(span);
    assign div_req.divisor  = {span, 1'b0};

    // Temperature of the current index minus the fraction, clamped to TEMP_MIN..TEMP_MAX.
    always_comb
    begin
        base_w = TW'(cfg.start_temperature);
        idx_w  = signed'(TW'(idx_reg));
        whole  = base_w + idx_w;
        temp   = (whole <<< 8) - signed'(TW'(frac_reg));
        priority if (temp < TMIN)
        begin
            clamped = TMIN;
        end
        else if (temp > TMAX)
        begin
            clamped = TMAX;
        end
        else
        begin
            clamped = temp;
        end
    end

    assign ram_wr_en   = (state_reg == ST_IDLE) && head_valid && !head.lookup;
    assign ram_wr_addr = AW'(head.index);
    assign ram_wr_data = head.value;
    assign ram_rd_addr = idx_next;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        reading_next = reading_reg;
        prev_next    = prev_reg;
        frac_next    = frac_reg;
        above_next   = above_reg;
        below_next   = below_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.lookup)
                    begin
                        reading_next = head.value;
                        last_next    = last_idx;
                        above_next   = 1'b0;
                        below_next   = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (hit && (idx_reg == '0))
                begin
                    above_next = 1'b1;
                    frac_next  = '0;
                    state_next = ST_FINISH;
                end
                else if (hit)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (idx_reg == last_reg)
                begin
                    below_next = 1'b1;
                    frac_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_next = ram_rd_data;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = div_rsp.quotient;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next                  = 1'b1;
                result_next.temperature_q8 = TEMP_W'(clamped);
                result_next.above_first    = above_reg;
                result_next.below_last     = below_reg;
                state_next                 = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        reading_reg <= reading_next;
        prev_reg    <= prev_next;
        frac_reg    <= frac_next;
        above_reg   <= above_next;
        below_reg   <= below_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> tb/dti_result_checker.sv
// Checker for the descending table interpolator: predicts lookup results and compares them.
module dti_result_checker
    import dti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    item,
    input  logic        done,
    input  out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    localparam int DEPTH = TABLE_DEPTH_DEFAULT;

    logic [VALUE_W-1:0] resist_table [0:DEPTH-1];
    logic signed [7:0]  start_temp;
    logic [7:0]         entries_reg;
    out_item_t          expected_temps [$];
    out_item_t          want;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Scan for the first entry at or below the reading, then interpolate back
    // toward the entry before it with round-half-up on the Q8 fraction.
    function automatic out_item_t convert_reading(input logic [VALUE_W-1:0] reading);
        out_item_t res;
        int        n;
        int        i;
        longint    base;
        longint    span;
        longint    frac;
        longint    temp;
        res = '0;
        n = (entries_reg == 0) ? 1 : ((entries_reg > DEPTH) ? DEPTH : int'(entries_reg));
        i = 0;
        while (i < n && reading < resist_table[i])
            i++;
        base = longint'(start_temp);
        if (i == 0)
        begin
            temp = base * 256;
            res.above_first = 1'b1;
        end
        else if (i >= n)
        begin
            temp = (base + n - 1) * 256;
            res.below_last = 1'b1;
        end
        else
        begin
            span = longint'(resist_table[i-1]) - longint'(resist_table[i]);
            frac = ((longint'(reading) - longint'(resist_table[i])) * 512 + span) / (2 * span);
            temp = (base + i) * 256 - frac;
        end
        if (temp < TEMP_MIN)
            temp = longint'(TEMP_MIN);
        if (temp > TEMP_MAX)
            temp = longint'(TEMP_MAX);
        res.temperature_q8 = temp[TEMP_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_temp  = START_RESET;
            entries_reg = ENTRIES_RESET;
            expected_temps.delete();
            pending = 0;
        end
        else
        begin
            // Results are handled before new lookups so that a result can
            // never be matched against a prediction made at the same edge.
            if (done)
            begin
                if (expected_temps.size() == 0)
                begin
                    $display("%0t: unexpected result: temperature_q8 %0d above_first %0b below_last %0b",
                             $time, result.temperature_q8, result.above_first, result.below_last);
                    errors++;
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (result.temperature_q8 !== want.temperature_q8)
                    begin
                        $display("%0t: temperature_q8 mismatch: expected %0d, actual %0d",
                                 $time, want.temperature_q8, result.temperature_q8);
                        errors++;
                    end
                    if (result.above_first !== want.above_first)
                    begin
                        $display("%0t: above_first mismatch: expected %0b, actual %0b",
                                 $time, want.above_first, result.above_first);
                        errors++;
                    end
                    if (result.below_last !== want.below_last)
                    begin
                        $display("%0t: below_last mismatch: expected %0b, actual %0b",
                                 $time, want.below_last, result.below_last);
                        errors++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_START)
                    start_temp = pwdata[7:0];
                else
                    entries_reg = pwdata[7:0];
            end
            if (start && !busy)
            begin
                if (item.command == CMD_LOAD)
                    resist_table[item.entry_index] = item.entry_value;
                else
                    expected_temps.push_back(convert_reading(item.search_value));
            end
            pending = expected_temps.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the descending table interpolator: stimulus, watchdog and verdict.
module tb
    import dti_pkg::*;
();

    // Random transactions after the directed part.
    localparam int RANDOM_ITEMS   = 950;
    // A lookup that scans the whole table is the longest transaction and the
    // queue holds two transactions, so SETTLE_CYCLES covers any work still in
    // flight after the last result has come out.
    localparam int SETTLE_CYCLES  = 400;
    // Longest correct stretch without any transaction is the settle time plus
    // a full queue of long lookups; this limit is several times that.
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    in_item_t    item    = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        busy;
    logic        done;
    out_item_t   result;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int sent         = 0;

    // Copy of the table contents, used only to steer readings into the table.
    logic [VALUE_W-1:0] shadow_table [0:TABLE_DEPTH_DEFAULT-1];

    descending_table_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dti_result_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The watchdog restarts whenever a transaction, a result or a register
    // access is accepted; a long silence means the block has hung.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout after %0d idle cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Entries that a lookup actually scans for a given register value.
    function automatic int scanned_entries(input logic [7:0] entries);
        if (entries == 0)
            return 1;
        if (entries > TABLE_DEPTH_DEFAULT)
            return TABLE_DEPTH_DEFAULT;
        return int'(entries);
    endfunction

    // Inputs change only at falling edges. Start stays high across a burst,
    // so it is never lowered and raised again within one time step.
    task automatic pause_cycles(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic send_transaction(input in_item_t t);
        if (burst_left == 0)
        begin
            // About one burst in four is long, giving stretches with no idling.
            pause_cycles($urandom_range(20, 1));
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(150, 60)
                                                     : $urandom_range(12, 1);
        end
        start <= 1'b1;
        item  <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent++;
    endtask

    // Lower start and wait until every predicted result has been seen.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. The upper
    // data bits carry junk, since only the low byte belongs to a register.
    task automatic write_register(input logic sel, input logic [7:0] value);
        logic [23:0] junk;
        junk = 24'($urandom());
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= {junk, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only while the block is idle: all results in, then
    // enough cycles for any trailing load to leave the queue.
    task automatic set_config(input logic [7:0] start_temp, input logic [7:0] entries);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(REG_START, start_temp);
        write_register(REG_ENTRIES, entries);
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value);
        in_item_t t;
        t.command      = CMD_LOAD;
        t.entry_index  = idx;
        t.entry_value  = value;
        t.search_value = VALUE_W'($urandom());
        shadow_table[idx] = value;
        send_transaction(t);
    endtask

    task automatic lookup(input logic [VALUE_W-1:0] reading);
        in_item_t t;
        t.command      = CMD_LOOKUP;
        t.entry_index  = INDEX_W'($urandom());
        t.entry_value  = VALUE_W'($urandom());
        t.search_value = reading;
        send_transaction(t);
    endtask

    // Mostly a falling table with random steps, some of them tiny; now and
    // then a table of random words.
    task automatic load_table(input int n, input bit scrambled);
        logic [VALUE_W-1:0] v;
        int                 max_step;
        int                 step;
        v = ($urandom_range(3, 0) == 0) ? 24'hFFFFFF : VALUE_W'($urandom_range(24'hFFFFFF, n));
        for (int k = 0; k < n; k++)
        begin
            load_entry(INDEX_W'(k), scrambled ? VALUE_W'($urandom()) : v);
            if (k < n - 1)
            begin
                max_step = v / (n - 1 - k);
                if (max_step == 0)
                    step = 0;
                else if ($urandom_range(3, 0) == 0)
                    step = $urandom_range(3, 1);
                else
                    step = $urandom_range(max_step, 1);
                if (step > v)
                    step = int'(v);
                v = v - VALUE_W'(step);
            end
        end
    endtask

    // Readings aimed mostly between two neighboring entries, with some at
    // entry values, above the first, below the last and fully random.
    function automatic logic [VALUE_W-1:0] pick_reading(input int n);
        int                 k;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] lo;
        case ($urandom_range(9, 0))
            0: return VALUE_W'($urandom());
            1: return shadow_table[INDEX_W'($urandom_range(n - 1, 0))];
            2: return VALUE_W'($urandom_range(24'hFFFFFF, shadow_table[0]));
            3: return (shadow_table[INDEX_W'(n - 1)] == 0) ? '0 :
                   VALUE_W'($urandom_range(shadow_table[INDEX_W'(n - 1)] - 1, 0));
            default:
            begin
                if (n < 2)
                    return VALUE_W'($urandom());
                k  = $urandom_range(n - 1, 1);
                hi = shadow_table[INDEX_W'(k - 1)];
                lo = shadow_table[INDEX_W'(k)];
                return (hi > lo) ? VALUE_W'($urandom_range(hi - 1, lo)) : lo;
            end
        endcase
    endfunction

    initial
    begin
        int               target;
        int               n;
        logic [7:0]       entries;
        logic signed [7:0] start_temp;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Directed part. The start temperature is left at its reset value for
        // the first lookups, so the default is checked too.
        write_register(REG_ENTRIES, 8'd3);
        load_entry(7'd0, 24'hFFFFFF);
        load_entry(7'd1, 24'h800000);
        load_entry(7'd2, 24'h000200);
        load_entry(7'd3, 24'h000000);
        lookup(24'hFFFFFF);     // equal to the first entry: start temperature
        lookup(24'hFFFFFE);     // just below the first entry: fraction near one
        lookup(24'h800000);     // exactly on an entry: whole degree
        lookup(24'h7FFFFF);     // interpolation in the second interval
        lookup(24'h000200);     // exactly on the last scanned entry
        lookup(24'h0001FF);     // below every scanned entry: saturates
        lookup(24'h000000);     // smallest reading, still below the table

        // Zero entries in use acts as a one-entry table, with the hottest start.
        set_config(8'sd127, 8'd0);
        lookup(24'hFFFFFF);
        lookup(24'h000000);

        // Coldest start; reading one in a span of 512 is a rounding tie.
        set_config(-8'sd128, 8'd4);
        lookup(24'h000001);
        lookup(24'h000000);

        // Random phases: a new setting, a fresh table, then mostly lookups
        // with a few stray loads that disturb the table mid-phase.
        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            case ($urandom_range(7, 0))
                0: entries = 8'd1;
                1: entries = 8'd0;
                2: entries = 8'd128;
                3: entries = 8'd255;
                4: entries = 8'd2;
                5, 6: entries = 8'($urandom_range(40, 3));
                default: entries = 8'($urandom_range(255, 0));
            endcase
            case ($urandom_range(3, 0))
                0: start_temp = -8'sd128;
                1: start_temp = 8'sd127;
                default: start_temp = 8'($urandom());
            endcase
            set_config(start_temp, entries);
            n = scanned_entries(entries);
            load_table(n, $urandom_range(5, 0) == 0);
            repeat ($urandom_range(100, 40))
            begin
                if ($urandom_range(11, 0) == 0)
                    load_entry(INDEX_W'($urandom_range(127, 0)), VALUE_W'($urandom()));
                else
                    lookup(pick_reading(n));
                // Occasionally hold off until the block has caught up.
                if ($urandom_range(59, 0) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
